// File: src/psq_pkg.sv
// psq_pkg: shared types, codes and constants of the presence state qualifier.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package psq_pkg;

   // default sizes of the saturating counters
   localparam int TICK_COUNTER_WIDTH_DEF = 16;
   localparam int PACKET_COUNT_WIDTH_DEF = 32;

   // port geometry
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 11;

   // field widths
   localparam int VERDICT_W   = 2;
   localparam int MM_W        = 16;
   localparam int CM_W        = 13;
   localparam int PRESENCE_W  = 2;
   localparam int COUNT_OUT_W = 32;
   localparam int SILENCE_W   = 11;
   localparam int CONFIRM_W   = 3;
   localparam int WINDOW_W    = 8;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SILENCE_TIMEOUT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONFIRM_REPORTS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CONFIRM_WINDOW  = 2'd2;

   // register reset values (30 s silence, one report, 6 s window)
   localparam logic [SILENCE_W-1:0] SILENCE_TIMEOUT_RST = 11'd300;
   localparam logic [CONFIRM_W-1:0] CONFIRM_REPORTS_RST = 3'd1;
   localparam logic [WINDOW_W-1:0]  CONFIRM_WINDOW_RST  = 8'd60;

   localparam logic [CONFIRM_W-1:0] CONFIRM_COUNT_MAX = 3'd7;

   // item kinds and verdicts
   localparam logic REQ_TICK   = 1'b0;
   localparam logic REQ_REPORT = 1'b1;
   localparam logic [VERDICT_W-1:0] VERDICT_ABSENT = 2'd0;

   // presence codes as seen on the result
   localparam logic [PRESENCE_W-1:0] PRESENCE_UNKNOWN  = 2'd0;
   localparam logic [PRESENCE_W-1:0] PRESENCE_ABSENT   = 2'd1;
   localparam logic [PRESENCE_W-1:0] PRESENCE_PRESENT  = 2'd2;
   localparam logic [PRESENCE_W-1:0] PRESENCE_RESERVED = 2'd3;

   // mm / 10 as (mm * 52429) >> 19, exact over 16 bits
   localparam int                DIV10_SHIFT = 19;
   localparam logic [MM_W:0]     DIV10_MULT  = 17'd52429;
   localparam int                DIV10_PROD_W = MM_W + DIV10_SHIFT - 2;

   typedef enum logic [2:0] {
      ST_UNKNOWN = 3'b001,
      ST_ABSENT  = 3'b010,
      ST_PRESENT = 3'b100
   } state_type;

   typedef struct packed {
      logic                  req_type;
      logic [VERDICT_W-1:0]  report_verdict;
      logic [MM_W-1:0]       distance_mm;
   } req_item_type;

   typedef struct packed {
      logic [COUNT_OUT_W-1:0] report_count;
      logic [CM_W-1:0]        range_cm;
      logic                   state_changed;
      logic [PRESENCE_W-1:0]  presence;
   } rsp_item_type;

   function automatic logic [PRESENCE_W-1:0] presence_code(input state_type st);
      logic [PRESENCE_W-1:0] code;
      case (st)
         ST_ABSENT:  code = PRESENCE_ABSENT;
         ST_PRESENT: code = PRESENCE_PRESENT;
         default:    code = PRESENCE_UNKNOWN;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// File: src/psq_in_stage.sv
// psq_in_stage: input register of the qualifier, holds one request beat.
// Depends on psq_pkg for the request item type.
`default_nettype none

module psq_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output      logic                  in_ready,
   input  wire psq_pkg::req_item_type in_item,
   input  wire logic                  advance,
   output      logic                  out_valid,
   output      psq_pkg::req_item_type out_item
);

   logic                  valid_ff, valid_in;
   psq_pkg::req_item_type item_ff, item_in;

   // room when empty or when the held beat moves on this cycle
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            item_in = in_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// File: src/psq_core.sv
// psq_core: configuration registers, qualifier state and its next-state logic.
// Depends on psq_pkg for codes, types and the divide-by-ten constants.
`default_nettype none

module psq_core #(
   parameter int TICK_COUNTER_WIDTH = psq_pkg::TICK_COUNTER_WIDTH_DEF,
   parameter int PACKET_COUNT_WIDTH = psq_pkg::PACKET_COUNT_WIDTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [psq_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [psq_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                              fire,
   input  wire psq_pkg::req_item_type             item,
   output      psq_pkg::rsp_item_type             result
);

   localparam int TW = TICK_COUNTER_WIDTH;
   localparam int PW = PACKET_COUNT_WIDTH;
   localparam int EXT_W = (PW > psq_pkg::COUNT_OUT_W) ? PW : psq_pkg::COUNT_OUT_W;

   logic [psq_pkg::SILENCE_W-1:0] silence_ff;
   logic [psq_pkg::CONFIRM_W-1:0] confirm_ff;
   logic [psq_pkg::WINDOW_W-1:0]  window_ff;

   psq_pkg::state_type            state_ff, state_in;
   logic [TW-1:0]                 tsr_ff, tsr_in;
   logic [TW-1:0]                 tss_ff, tss_in;
   logic                          cand_ff, cand_in;
   logic [TW-1:0]                 tiw_ff, tiw_in;
   logic [psq_pkg::CONFIRM_W-1:0] cnt_ff, cnt_in;
   logic [psq_pkg::CM_W-1:0]      dist_ff, dist_in;
   logic [PW-1:0]                 pkt_ff, pkt_in;

   logic [psq_pkg::DIV10_PROD_W-1:0] div_prod;
   logic [psq_pkg::CONFIRM_W-1:0]    cnt_new;
   logic [TW-1:0]                    silence_ext;
   logic [TW-1:0]                    window_ext;
   logic                             window_over;
   logic [EXT_W-1:0]                 pkt_ext;

   assign silence_ext = TW'(silence_ff);
   assign window_ext  = TW'(window_ff);
   assign window_over = tiw_ff > window_ext;

   assign div_prod = psq_pkg::DIV10_PROD_W'(item.distance_mm) *
                     psq_pkg::DIV10_PROD_W'(psq_pkg::DIV10_MULT);

   always_comb begin
      state_in = state_ff;
      tsr_in   = tsr_ff;
      tss_in   = tss_ff;
      cand_in  = cand_ff;
      tiw_in   = tiw_ff;
      cnt_in   = cnt_ff;
      dist_in  = dist_ff;
      pkt_in   = pkt_ff;
      cnt_new  = cnt_ff;

      if (item.req_type == psq_pkg::REQ_REPORT) begin
         tsr_in = '0;
         pkt_in = (pkt_ff == {PW{1'b1}}) ? pkt_ff : pkt_ff + 1'b1;
         if (item.distance_mm != '0) begin
            dist_in = div_prod[psq_pkg::DIV10_SHIFT +: psq_pkg::CM_W];
         end
         if (item.report_verdict == psq_pkg::VERDICT_ABSENT) begin
            if (state_ff != psq_pkg::ST_ABSENT) begin
               state_in = psq_pkg::ST_ABSENT;
               cand_in  = 1'b0;
               cnt_in   = '0;
               tiw_in   = '0;
            end
         end else if (state_ff != psq_pkg::ST_PRESENT) begin
            // invalid verdicts count like present ones
            if (!cand_ff || window_over) begin
               cnt_new = psq_pkg::CONFIRM_W'(1);
               tiw_in  = '0;
            end else if (cnt_ff != psq_pkg::CONFIRM_COUNT_MAX) begin
               cnt_new = cnt_ff + 1'b1;
            end
            if (cnt_new >= confirm_ff) begin
               state_in = psq_pkg::ST_PRESENT;
               cand_in  = 1'b0;
               cnt_in   = '0;
               tiw_in   = '0;
            end else begin
               cand_in = 1'b1;
               cnt_in  = cnt_new;
            end
         end
      end else begin
         tsr_in = (tsr_ff == {TW{1'b1}}) ? tsr_ff : tsr_ff + 1'b1;
         tss_in = (tss_ff == {TW{1'b1}}) ? tss_ff : tss_ff + 1'b1;
         if (cand_ff && (tiw_ff != {TW{1'b1}})) begin
            tiw_in = tiw_ff + 1'b1;
         end
         // silence timeout first, then window expiry, then start-up deadline
         if (state_ff == psq_pkg::ST_PRESENT) begin
            if (tsr_in >= silence_ext) begin
               state_in = psq_pkg::ST_ABSENT;
               cand_in  = 1'b0;
               cnt_in   = '0;
               tiw_in   = '0;
            end
         end else if (cand_ff) begin
            if (tiw_in > window_ext) begin
               cand_in = 1'b0;
               cnt_in  = '0;
               tiw_in  = '0;
            end
         end else if (state_ff == psq_pkg::ST_UNKNOWN) begin
            if (tss_in >= silence_ext) begin
               state_in = psq_pkg::ST_ABSENT;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         silence_ff <= psq_pkg::SILENCE_TIMEOUT_RST;
         confirm_ff <= psq_pkg::CONFIRM_REPORTS_RST;
         window_ff  <= psq_pkg::CONFIRM_WINDOW_RST;
      end else if (csr_we) begin
         case (csr_index)
            psq_pkg::CSR_SILENCE_TIMEOUT: silence_ff <= csr_wdata;
            psq_pkg::CSR_CONFIRM_REPORTS: confirm_ff <= csr_wdata[psq_pkg::CONFIRM_W-1:0];
            psq_pkg::CSR_CONFIRM_WINDOW:  window_ff  <= csr_wdata[psq_pkg::WINDOW_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psq_pkg::ST_UNKNOWN;
         tsr_ff   <= '0;
         tss_ff   <= '0;
         cand_ff  <= 1'b0;
         tiw_ff   <= '0;
         cnt_ff   <= '0;
         dist_ff  <= '0;
         pkt_ff   <= '0;
      end else if (fire) begin
         state_ff <= state_in;
         tsr_ff   <= tsr_in;
         tss_ff   <= tss_in;
         cand_ff  <= cand_in;
         tiw_ff   <= tiw_in;
         cnt_ff   <= cnt_in;
         dist_ff  <= dist_in;
         pkt_ff   <= pkt_in;
      end
   end

   assign pkt_ext = EXT_W'(pkt_in);

   always_comb begin
      result.presence      = psq_pkg::presence_code(state_in);
      result.state_changed = state_in != state_ff;
      result.range_cm      = dist_in;
      result.report_count  = pkt_ext[psq_pkg::COUNT_OUT_W-1:0];
   end

endmodule

`default_nettype wire

// File: src/psq_out_stage.sv
// psq_out_stage: result register of the qualifier, holds one response beat.
// Depends on psq_pkg for the result item type.
`default_nettype none

module psq_out_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire psq_pkg::rsp_item_type in_item,
   output      logic                  advance,
   output      logic                  out_valid,
   input  wire logic                  out_ready,
   output      psq_pkg::rsp_item_type out_item
);

   logic                  valid_ff, valid_in;
   psq_pkg::rsp_item_type item_ff, item_in;

   // load when empty or when the held beat is taken this cycle
   assign advance = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (advance) begin
         valid_in = in_valid;
         if (in_valid) begin
            item_in = in_item;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// File: src/presence_state_qualifier_unit.sv
// presence_state_qualifier_unit: top level, stream ports and csr write port.
// Depends on psq_pkg, psq_in_stage, psq_core and psq_out_stage.
//
// Takes one request beat per clock while req_tready is high (a 100 ms tick or a decoded
// sensor report) and returns exactly one response beat per request, in order, through the
// input register and then the response register. Throughput is one beat per cycle while the
// response side is ready, set by the state update in psq_core between the two registers; a
// stalled response register backs up into the input register, and req_tready falls only when
// both hold a beat. The user must write registers through csr_we/csr_index/csr_wdata only
// while no beat is in flight; the block does not enforce it. No clearing pass after reset.
`default_nettype none

module presence_state_qualifier_unit #(
   parameter int TICK_COUNTER_WIDTH = psq_pkg::TICK_COUNTER_WIDTH_DEF,
   parameter int PACKET_COUNT_WIDTH = psq_pkg::PACKET_COUNT_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   // [1:0] report_verdict, [17:2] distance_mm, [23:18] zero
   input  wire logic [psq_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [0] req_type
   input  wire logic                             req_tuser,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [1:0] presence, [2] state_changed, [15:3] range_cm, [47:16] report_count
   output      logic [psq_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [psq_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [psq_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   psq_pkg::req_item_type req_item;
   psq_pkg::req_item_type held_item;
   psq_pkg::rsp_item_type core_result;
   psq_pkg::rsp_item_type rsp_item;
   logic                  held_valid;
   logic                  advance;
   logic                  fire;

   always_comb begin
      req_item.req_type       = req_tuser;
      req_item.report_verdict = req_tdata[psq_pkg::VERDICT_W-1:0];
      req_item.distance_mm    = req_tdata[psq_pkg::VERDICT_W +: psq_pkg::MM_W];
   end

   psq_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .advance   (advance),
      .out_valid (held_valid),
      .out_item  (held_item)
   );

   assign fire = held_valid && advance;

   psq_core #(
      .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH),
      .PACKET_COUNT_WIDTH (PACKET_COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .fire      (fire),
      .item      (held_item),
      .result    (core_result)
   );

   psq_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (held_valid),
      .in_item   (core_result),
      .advance   (advance),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_item  (rsp_item)
   );

   assign rsp_tdata = {rsp_item.report_count, rsp_item.range_cm,
                       rsp_item.state_changed, rsp_item.presence};

   // a beat leaving the input register lands in the response register
   a_fire_lands: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid)
      else $error("processed beat did not reach the response register");

   // input side never takes a beat while the held one is stuck
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && held_valid && !advance))
      else $error("input register overrun");

   // the reserved presence code never appears on a response beat
   a_presence_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[psq_pkg::PRESENCE_W-1:0] != psq_pkg::PRESENCE_RESERVED))
      else $error("reserved presence code on response");

   // pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      ($past(reset) && !reset) |-> (!rsp_tvalid && !held_valid))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
